### hdl/gkmb_pkg.sv
// Package for the green key mask and boundary replace unit.
// Holds sizes, key colors, class and register codes and ring pointer helpers.
// No dependencies.
package gkmb_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int SIZE_W = 11;
   localparam int COORD_W = 10;
   localparam int FETCH_W = 20;
   localparam int CLASS_W = 2;
   localparam int COLOR_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int RING_SW = RING_AW + 1;
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);

   localparam logic [COLOR_W-1:0] KEY_OPAQUE = 32'hff00ff00;
   localparam logic [COLOR_W-1:0] KEY_CLEAR = 32'h0000ff00;

   localparam logic [CLASS_W-1:0] CLASS_SOURCE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_INTERIOR = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_BOUNDARY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd3;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET = 11'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
   localparam logic [SIZE_W-1:0] SRC_WIDTH_RESET = 11'd640;
   localparam logic [SIZE_W-1:0] SRC_HEIGHT_RESET = 11'd480;

   // Forces a size register into the range 1 to limit.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > limit) begin
         r = limit;
      end
      return r;
   endfunction

   // Ring pointer plus an offset of at most one line, modulo the ring depth.
   function automatic logic [RING_AW-1:0] ring_fwd(input logic [RING_AW-1:0] a,
                                                   input logic [SIZE_W-1:0] b);
      logic [RING_SW-1:0] s;
      s = RING_SW'(a) + RING_SW'(b);
      if (s >= RING_SW'(RING_DEPTH)) begin
         s = s - RING_SW'(RING_DEPTH);
      end
      return s[RING_AW-1:0];
   endfunction

   // Ring pointer minus an offset of at most one line, modulo the ring depth.
   function automatic logic [RING_AW-1:0] ring_back(input logic [RING_AW-1:0] a,
                                                    input logic [SIZE_W-1:0] b);
      logic [RING_SW-1:0] s;
      if (RING_SW'(a) >= RING_SW'(b)) begin
         s = RING_SW'(a) - RING_SW'(b);
      end else begin
         s = RING_SW'(a) + RING_SW'(RING_DEPTH) - RING_SW'(b);
      end
      return s[RING_AW-1:0];
   endfunction

endpackage

### hdl/green_key_mask_boundary_replace_unit.sv
// Top level of the green key mask and boundary replace unit.
// Depends on gkmb_pkg for sizes, codes and ring pointer helpers.

// The unit takes one beat per clock on the request channel and gives each pixel's
// result one frame row later, once the pixel below it has arrived; flush beats
// drain the last row. A beat is accepted in every cycle unless the one-entry
// stage behind the mask line store and the result register are both held.
// A result passes the stage register and then the result register after the
// beat that releases it. The key mask lives in a ring of 2*1024+1 one-bit
// entries, kept in three copies so that the five neighbor reads happen in the
// same cycle; the ring is not cleared after reset, so the unit is ready at once.
// Size registers should be written only while the unit is idle.
module green_key_mask_boundary_replace_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [gkmb_pkg::COLOR_W-1:0]          req_pixel_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gkmb_pkg::CLASS_W-1:0]          rsp_mark_class,
   output logic                                  rsp_replace,
   output logic [gkmb_pkg::FETCH_W-1:0]          rsp_fetch_addr,
   output logic [gkmb_pkg::COORD_W-1:0]          rsp_pos_x,
   output logic [gkmb_pkg::COORD_W-1:0]          rsp_pos_y,
   output logic [gkmb_pkg::SIZE_W-1:0]           rsp_box_top,
   output logic [gkmb_pkg::COORD_W-1:0]          rsp_box_bottom,
   output logic [gkmb_pkg::SIZE_W-1:0]           rsp_box_left,
   output logic [gkmb_pkg::COORD_W-1:0]          rsp_box_right,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gkmb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gkmb_pkg::SIZE_W-1:0]           csr_data
);

   typedef struct packed {
      logic [gkmb_pkg::COORD_W-1:0] x;
      logic [gkmb_pkg::COORD_W-1:0] y;
      logic [gkmb_pkg::SIZE_W-1:0]  w;
      logic [gkmb_pkg::SIZE_W-1:0]  h;
      logic [gkmb_pkg::SIZE_W-1:0]  sw;
      logic [gkmb_pkg::COORD_W-1:0] fx;
      logic [gkmb_pkg::COORD_W-1:0] fy;
      logic                         edge_px;
      logic                         last;
      logic                         rt_ok;
      logic                         dn_ok;
      logic                         new_bit;
      logic                         hit_c;
      logic                         hit_l;
      logic                         hit_r;
      logic                         hit_u;
      logic                         hit_d;
   } stage_type;

   localparam logic [gkmb_pkg::SIZE_W-1:0] WIDTH_LIMIT = gkmb_pkg::SIZE_W'(gkmb_pkg::MAX_WIDTH);
   localparam logic [gkmb_pkg::SIZE_W-1:0] HEIGHT_LIMIT =
      gkmb_pkg::SIZE_W'(gkmb_pkg::MAX_HEIGHT);
   localparam logic [gkmb_pkg::SIZE_W-1:0] SRC_LIMIT = '1;

   logic [gkmb_pkg::SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [gkmb_pkg::SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic [gkmb_pkg::SIZE_W-1:0] src_width_ff, src_width_in;
   logic [gkmb_pkg::SIZE_W-1:0] src_height_ff, src_height_in;

   logic [gkmb_pkg::RING_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gkmb_pkg::RING_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gkmb_pkg::PEND_W-1:0]  pending_ff, pending_in;
   logic [gkmb_pkg::COORD_W-1:0] out_col_ff, out_col_in;
   logic [gkmb_pkg::COORD_W-1:0] out_row_ff, out_row_in;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   logic mask_a_ff [gkmb_pkg::RING_DEPTH];
   logic mask_b_ff [gkmb_pkg::RING_DEPTH];
   logic mask_c_ff [gkmb_pkg::RING_DEPTH];
   logic rd_c_ff, rd_l_ff, rd_r_ff, rd_u_ff, rd_d_ff;

   logic [gkmb_pkg::SIZE_W-1:0]  box_top_ff, box_top_in;
   logic [gkmb_pkg::COORD_W-1:0] box_bottom_ff, box_bottom_in;
   logic [gkmb_pkg::SIZE_W-1:0]  box_left_ff, box_left_in;
   logic [gkmb_pkg::COORD_W-1:0] box_right_ff, box_right_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gkmb_pkg::CLASS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic                          rsp_replace_ff, rsp_replace_in;
   logic [gkmb_pkg::FETCH_W-1:0]  rsp_fetch_ff, rsp_fetch_in;
   logic [gkmb_pkg::COORD_W-1:0]  rsp_x_ff, rsp_x_in;
   logic [gkmb_pkg::COORD_W-1:0]  rsp_y_ff, rsp_y_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic out_free, s1_move, accept, is_pixel, new_bit, emit_now;
   logic [gkmb_pkg::SIZE_W-1:0]  eff_w, eff_h, eff_sw, eff_sh;
   logic [gkmb_pkg::PEND_W-1:0]  pend_now;
   logic [gkmb_pkg::RING_AW-1:0] addr_c, addr_l, addr_r, addr_u, addr_d;

   assign eff_w = gkmb_pkg::clamp_size(frame_width_ff, WIDTH_LIMIT);
   assign eff_h = gkmb_pkg::clamp_size(frame_height_ff, HEIGHT_LIMIT);
   assign eff_sw = gkmb_pkg::clamp_size(src_width_ff, SRC_LIMIT);
   assign eff_sh = gkmb_pkg::clamp_size(src_height_ff, SRC_LIMIT);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign is_pixel = !req_kind;
   assign new_bit = (req_pixel_color == gkmb_pkg::KEY_OPAQUE) ||
                    (req_pixel_color == gkmb_pkg::KEY_CLEAR);
   assign pend_now = is_pixel ? pending_ff + gkmb_pkg::PEND_W'(1) : pending_ff;
   assign emit_now = is_pixel ? (32'(pend_now) > 32'(eff_w)) : (pending_ff != '0);

   assign addr_c = rd_ptr_ff;
   assign addr_l = gkmb_pkg::ring_back(rd_ptr_ff, gkmb_pkg::SIZE_W'(1));
   assign addr_r = gkmb_pkg::ring_fwd(rd_ptr_ff, gkmb_pkg::SIZE_W'(1));
   assign addr_u = gkmb_pkg::ring_back(rd_ptr_ff, eff_w);
   assign addr_d = gkmb_pkg::ring_fwd(rd_ptr_ff, eff_w);

   always_comb begin
      frame_width_in = frame_width_ff;
      frame_height_in = frame_height_ff;
      src_width_in = src_width_ff;
      src_height_in = src_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gkmb_pkg::CSR_FRAME_WIDTH: frame_width_in = csr_data;
            gkmb_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            gkmb_pkg::CSR_SRC_WIDTH: src_width_in = csr_data;
            gkmb_pkg::CSR_SRC_HEIGHT: src_height_in = csr_data;
            default: frame_width_in = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      logic [gkmb_pkg::SIZE_W-1:0] x_next;
      logic [gkmb_pkg::SIZE_W-1:0] y_next;
      logic                        col_end;
      logic                        row_end;
      x_next = gkmb_pkg::SIZE_W'(out_col_ff) + gkmb_pkg::SIZE_W'(1);
      y_next = gkmb_pkg::SIZE_W'(out_row_ff) + gkmb_pkg::SIZE_W'(1);
      col_end = x_next >= eff_w;
      row_end = y_next >= eff_h;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      pending_in = pending_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (is_pixel) begin
            wr_ptr_in = gkmb_pkg::ring_fwd(wr_ptr_ff, gkmb_pkg::SIZE_W'(1));
         end
         pending_in = pend_now;
         if (emit_now) begin
            rd_ptr_in = addr_r;
            pending_in = pend_now - gkmb_pkg::PEND_W'(1);
            if (col_end) begin
               out_col_in = '0;
               out_row_in = row_end ? '0 : y_next[gkmb_pkg::COORD_W-1:0];
            end else begin
               out_col_in = x_next[gkmb_pkg::COORD_W-1:0];
            end
         end
      end

      s1_in.x = out_col_ff;
      s1_in.y = out_row_ff;
      s1_in.w = eff_w;
      s1_in.h = eff_h;
      s1_in.sw = eff_sw;
      s1_in.fx = (gkmb_pkg::SIZE_W'(out_col_ff) >= eff_sw) ?
                 gkmb_pkg::COORD_W'(eff_sw - gkmb_pkg::SIZE_W'(1)) : out_col_ff;
      s1_in.fy = (gkmb_pkg::SIZE_W'(out_row_ff) >= eff_sh) ?
                 gkmb_pkg::COORD_W'(eff_sh - gkmb_pkg::SIZE_W'(1)) : out_row_ff;
      s1_in.edge_px = (out_col_ff == '0) || (out_row_ff == '0) || col_end || row_end;
      s1_in.last = col_end && row_end;
      s1_in.rt_ok = 32'(pend_now) >= 32'd2;
      s1_in.dn_ok = 32'(pend_now) >= 32'(eff_w) + 32'd1;
      s1_in.new_bit = new_bit;
      s1_in.hit_c = is_pixel && (addr_c == wr_ptr_ff);
      s1_in.hit_l = is_pixel && (addr_l == wr_ptr_ff);
      s1_in.hit_r = is_pixel && (addr_r == wr_ptr_ff);
      s1_in.hit_u = is_pixel && (addr_u == wr_ptr_ff);
      s1_in.hit_d = is_pixel && (addr_d == wr_ptr_ff);

      if (accept) begin
         s1_valid_in = emit_now;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_pixel) begin
            mask_a_ff[wr_ptr_ff] <= new_bit;
            mask_b_ff[wr_ptr_ff] <= new_bit;
            mask_c_ff[wr_ptr_ff] <= new_bit;
         end
         rd_c_ff <= mask_a_ff[addr_c];
         rd_l_ff <= mask_a_ff[addr_l];
         rd_r_ff <= mask_b_ff[addr_r];
         rd_u_ff <= mask_b_ff[addr_u];
         rd_d_ff <= mask_c_ff[addr_d];
      end
   end

   always_comb begin
      logic                                  tgt;
      logic                                  up;
      logic                                  lf;
      logic                                  rt;
      logic                                  dn;
      logic                                  boundary;
      logic [gkmb_pkg::SIZE_W-1:0]           base_top;
      logic [gkmb_pkg::COORD_W-1:0]          base_bottom;
      logic [gkmb_pkg::SIZE_W-1:0]           base_left;
      logic [gkmb_pkg::COORD_W-1:0]          base_right;
      logic [gkmb_pkg::SIZE_W+gkmb_pkg::COORD_W:0] product;

      tgt = s1_ff.hit_c ? s1_ff.new_bit : rd_c_ff;
      up = s1_ff.hit_u ? s1_ff.new_bit : rd_u_ff;
      lf = s1_ff.hit_l ? s1_ff.new_bit : rd_l_ff;
      rt = s1_ff.rt_ok && (s1_ff.hit_r ? s1_ff.new_bit : rd_r_ff);
      dn = s1_ff.dn_ok && (s1_ff.hit_d ? s1_ff.new_bit : rd_d_ff);
      boundary = s1_ff.edge_px || !(up && lf && rt && dn);

      if ((s1_ff.x == '0) && (s1_ff.y == '0)) begin
         base_top = s1_ff.h;
         base_bottom = '0;
         base_left = s1_ff.w;
         base_right = '0;
      end else begin
         base_top = box_top_ff;
         base_bottom = box_bottom_ff;
         base_left = box_left_ff;
         base_right = box_right_ff;
      end

      box_top_in = base_top;
      box_bottom_in = base_bottom;
      box_left_in = base_left;
      box_right_in = base_right;
      if (tgt) begin
         if (gkmb_pkg::SIZE_W'(s1_ff.y) < base_top) begin
            box_top_in = gkmb_pkg::SIZE_W'(s1_ff.y);
         end
         if (s1_ff.y > base_bottom) begin
            box_bottom_in = s1_ff.y;
         end
         if (gkmb_pkg::SIZE_W'(s1_ff.x) < base_left) begin
            box_left_in = gkmb_pkg::SIZE_W'(s1_ff.x);
         end
         if (s1_ff.x > base_right) begin
            box_right_in = s1_ff.x;
         end
      end
      if (!s1_move) begin
         box_top_in = box_top_ff;
         box_bottom_in = box_bottom_ff;
         box_left_in = box_left_ff;
         box_right_in = box_right_ff;
      end

      product = (gkmb_pkg::SIZE_W+gkmb_pkg::COORD_W+1)'(s1_ff.fy) *
                (gkmb_pkg::SIZE_W+gkmb_pkg::COORD_W+1)'(s1_ff.sw) +
                (gkmb_pkg::SIZE_W+gkmb_pkg::COORD_W+1)'(s1_ff.fx);

      rsp_class_in = tgt ? (boundary ? gkmb_pkg::CLASS_BOUNDARY : gkmb_pkg::CLASS_INTERIOR) :
                           gkmb_pkg::CLASS_SOURCE;
      rsp_replace_in = tgt;
      rsp_fetch_in = product[gkmb_pkg::FETCH_W-1:0];
      rsp_x_in = s1_ff.x;
      rsp_y_in = s1_ff.y;
      rsp_last_in = s1_ff.last;

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= gkmb_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= gkmb_pkg::FRAME_HEIGHT_RESET;
         src_width_ff <= gkmb_pkg::SRC_WIDTH_RESET;
         src_height_ff <= gkmb_pkg::SRC_HEIGHT_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         pending_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         box_top_ff <= gkmb_pkg::FRAME_HEIGHT_RESET;
         box_bottom_ff <= '0;
         box_left_ff <= gkmb_pkg::FRAME_WIDTH_RESET;
         box_right_ff <= '0;
      end else begin
         frame_width_ff <= frame_width_in;
         frame_height_ff <= frame_height_in;
         src_width_ff <= src_width_in;
         src_height_ff <= src_height_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         pending_ff <= pending_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         box_top_ff <= box_top_in;
         box_bottom_ff <= box_bottom_in;
         box_left_ff <= box_left_in;
         box_right_ff <= box_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_class_ff <= rsp_class_in;
         rsp_replace_ff <= rsp_replace_in;
         rsp_fetch_ff <= rsp_fetch_in;
         rsp_x_ff <= rsp_x_in;
         rsp_y_ff <= rsp_y_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mark_class = rsp_class_ff;
   assign rsp_replace = rsp_replace_ff;
   assign rsp_fetch_addr = rsp_fetch_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_box_top = box_top_ff;
   assign rsp_box_bottom = box_bottom_ff;
   assign rsp_box_left = box_left_ff;
   assign rsp_box_right = box_right_ff;
   assign rsp_last = rsp_last_ff;

endmodule

### hdl/gkmb_checker.sv
// Port checker for the green key mask and boundary replace unit, with its bind.
// Depends on gkmb_pkg for field widths and class codes.
module gkmb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gkmb_pkg::CLASS_W-1:0]  rsp_mark_class,
   input logic                          rsp_replace,
   input logic [gkmb_pkg::FETCH_W-1:0]  rsp_fetch_addr,
   input logic [gkmb_pkg::COORD_W-1:0]  rsp_pos_x,
   input logic [gkmb_pkg::COORD_W-1:0]  rsp_pos_y,
   input logic [gkmb_pkg::SIZE_W-1:0]   rsp_box_top,
   input logic [gkmb_pkg::COORD_W-1:0]  rsp_box_bottom,
   input logic [gkmb_pkg::SIZE_W-1:0]   rsp_box_left,
   input logic [gkmb_pkg::COORD_W-1:0]  rsp_box_right
);

   // A held result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fetch_addr) &&
         $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_mark_class))
      else $error("result beat changed while stalled");

   // The replace flag agrees with the class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_replace == (rsp_mark_class != gkmb_pkg::CLASS_SOURCE)) &&
         (rsp_mark_class != 2'd3))
      else $error("class and replace flag disagree");

   // A target always lies inside the box that the same beat reports.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replace |->
         (rsp_box_left <= gkmb_pkg::SIZE_W'(rsp_pos_x)) && (rsp_box_right >= rsp_pos_x) &&
         (rsp_box_top <= gkmb_pkg::SIZE_W'(rsp_pos_y)) && (rsp_box_bottom >= rsp_pos_y))
      else $error("target outside reported box");

   // A first pixel of a frame that is not a target shows a restarted box.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_replace && (rsp_pos_x == '0) && (rsp_pos_y == '0) |->
         (rsp_box_bottom == '0) && (rsp_box_right == '0))
      else $error("box not restarted at frame start");

endmodule

bind green_key_mask_boundary_replace_unit gkmb_checker u_gkmb_checker (.*);

### tb/tb_green_key_mask_boundary_replace_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for green_key_mask_boundary_replace_unit.
// Holds a scoreboard class that predicts the key mask, class, fetch address and box per pixel.
// Depends on gkmb_pkg and the unit's top level.
module tb_green_key_mask_boundary_replace_unit;
   import gkmb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;
   localparam logic [COLOR_W-1:0] DIRECTED_4X4 [16] = '{
      KEY_OPAQUE, KEY_OPAQUE, KEY_OPAQUE, KEY_OPAQUE,
      KEY_OPAQUE, KEY_CLEAR, KEY_CLEAR, KEY_OPAQUE,
      KEY_CLEAR, KEY_OPAQUE, 32'hff00ff01, KEY_OPAQUE,
      32'hffffffff, 32'h00000000, KEY_OPAQUE, KEY_CLEAR
   };

   typedef struct packed {
      logic [CLASS_W-1:0] mark_class;
      logic replace;
      logic [FETCH_W-1:0] fetch_addr;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [SIZE_W-1:0] box_top;
      logic [COORD_W-1:0] box_bottom;
      logic [SIZE_W-1:0] box_left;
      logic [COORD_W-1:0] box_right;
      logic last;
   } pixel_mark_t;

   class mask_scoreboard;
      logic [SIZE_W-1:0] frame_w, frame_h, src_w, src_h;
      bit key_mask [RING_DEPTH];
      int unsigned wr_ptr, out_col, out_row, ring_fill;
      int unsigned box_top_q, box_bottom_q, box_left_q, box_right_q;
      pixel_mark_t expected_marks [$];
      int mismatches, results_checked, interior_seen, boundary_seen;

      function new();
         frame_w = FRAME_WIDTH_RESET;
         frame_h = FRAME_HEIGHT_RESET;
         src_w = SRC_WIDTH_RESET;
         src_h = SRC_HEIGHT_RESET;
         wr_ptr = 0;
         out_col = 0;
         out_row = 0;
         ring_fill = 0;
         box_top_q = eff_height();
         box_bottom_q = 0;
         box_left_q = eff_width();
         box_right_q = 0;
         mismatches = 0;
         results_checked = 0;
         interior_seen = 0;
         boundary_seen = 0;
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = frame_w;
         if (w == 0) begin
            w = 1;
         end else if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
         end
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = frame_h;
         if (h == 0) begin
            h = 1;
         end else if (h > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
         end
         return h;
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH: frame_w = data;
            CSR_FRAME_HEIGHT: frame_h = data;
            CSR_SRC_WIDTH: src_w = data;
            CSR_SRC_HEIGHT: src_h = data;
            default: ;
         endcase
      endfunction

      function void retire_oldest_pixel();
         int unsigned w, h, sw, sh, x, y, pos, fx, fy;
         bit is_key, on_border, up_k, left_k, right_k, down_k;
         longint unsigned addr;
         pixel_mark_t m;
         w = eff_width();
         h = eff_height();
         sw = (src_w == 0) ? 1 : src_w;
         sh = (src_h == 0) ? 1 : src_h;
         x = out_col;
         y = out_row;
         pos = (wr_ptr + RING_DEPTH - ring_fill) % RING_DEPTH;
         is_key = key_mask[pos];
         if (x == 0 && y == 0) begin
            box_top_q = h;
            box_bottom_q = 0;
            box_left_q = w;
            box_right_q = 0;
         end
         m.mark_class = CLASS_SOURCE;
         if (is_key) begin
            on_border = (x == 0) || (y == 0) || (x + 1 >= w) || (y + 1 >= h);
            if (!on_border) begin
               up_k = key_mask[(pos + RING_DEPTH - w) % RING_DEPTH];
               left_k = key_mask[(pos + RING_DEPTH - 1) % RING_DEPTH];
               right_k = ring_fill >= 2 && key_mask[(pos + 1) % RING_DEPTH];
               down_k = ring_fill >= w + 1 && key_mask[(pos + w) % RING_DEPTH];
               on_border = !(up_k && left_k && right_k && down_k);
            end
            if (on_border) begin
               m.mark_class = CLASS_BOUNDARY;
               boundary_seen++;
            end else begin
               m.mark_class = CLASS_INTERIOR;
               interior_seen++;
            end
            if (x < box_left_q) box_left_q = x;
            if (x > box_right_q) box_right_q = x;
            if (y < box_top_q) box_top_q = y;
            if (y > box_bottom_q) box_bottom_q = y;
         end
         fx = (x >= sw) ? sw - 1 : x;
         fy = (y >= sh) ? sh - 1 : y;
         addr = fy;
         addr = addr * sw + fx;
         m.replace = is_key;
         m.fetch_addr = FETCH_W'(addr);
         m.pos_x = COORD_W'(x);
         m.pos_y = COORD_W'(y);
         m.box_top = SIZE_W'(box_top_q);
         m.box_bottom = COORD_W'(box_bottom_q);
         m.box_left = SIZE_W'(box_left_q);
         m.box_right = COORD_W'(box_right_q);
         m.last = (x + 1 >= w) && (y + 1 >= h);
         expected_marks.push_back(m);
         if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
         end else begin
            out_col++;
         end
         ring_fill--;
      endfunction

      function void note_pixel_beat(logic kind, logic [COLOR_W-1:0] color);
         if (kind == KIND_FLUSH) begin
            if (ring_fill != 0) retire_oldest_pixel();
         end else begin
            key_mask[wr_ptr] = (color == KEY_OPAQUE) || (color == KEY_CLEAR);
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            ring_fill++;
            if (ring_fill > eff_width()) retire_oldest_pixel();
         end
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result_beat(pixel_mark_t got);
         pixel_mark_t want;
         results_checked++;
         if (expected_marks.size() == 0) begin
            $error("Result beat at (%0d,%0d) with no pixel awaiting it", got.pos_x, got.pos_y);
            mismatches++;
            return;
         end
         want = expected_marks.pop_front();
         compare_field("mark_class", want.mark_class, got.mark_class);
         compare_field("replace", want.replace, got.replace);
         compare_field("fetch_addr", want.fetch_addr, got.fetch_addr);
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("box_top", want.box_top, got.box_top);
         compare_field("box_bottom", want.box_bottom, got.box_bottom);
         compare_field("box_left", want.box_left, got.box_left);
         compare_field("box_right", want.box_right, got.box_right);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = KIND_PIXEL;
   logic [COLOR_W-1:0] req_pixel_color = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CLASS_W-1:0] rsp_mark_class;
   logic rsp_replace;
   logic [FETCH_W-1:0] rsp_fetch_addr;
   logic [COORD_W-1:0] rsp_pos_x;
   logic [COORD_W-1:0] rsp_pos_y;
   logic [SIZE_W-1:0] rsp_box_top;
   logic [COORD_W-1:0] rsp_box_bottom;
   logic [SIZE_W-1:0] rsp_box_left;
   logic [COORD_W-1:0] rsp_box_right;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_data = '0;

   pixel_mark_t rsp_fields;
   mask_scoreboard sb;
   int sender_idle_pct = 0;
   int sink_idle_pct = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int size_settings = 0;
   int flush_beats = 0;
   int pixel_beats = 0;

   green_key_mask_boundary_replace_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_pixel_color(req_pixel_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mark_class(rsp_mark_class),
      .rsp_replace(rsp_replace),
      .rsp_fetch_addr(rsp_fetch_addr),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_box_top(rsp_box_top),
      .rsp_box_bottom(rsp_box_bottom),
      .rsp_box_left(rsp_box_left),
      .rsp_box_right(rsp_box_right),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   assign rsp_fields = '{rsp_mark_class, rsp_replace, rsp_fetch_addr, rsp_pos_x, rsp_pos_y,
                         rsp_box_top, rsp_box_bottom, rsp_box_left, rsp_box_right, rsp_last};

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         stall_left = $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result_beat(rsp_fields);
      end
   end

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         2: return 12;
         default: return 30;
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color(int target_pct);
      logic [COLOR_W-1:0] key;
      key = $urandom_range(0, 1) ? KEY_OPAQUE : KEY_CLEAR;
      if ($urandom_range(0, 99) < target_pct) return key;
      case ($urandom_range(0, 2))
         0: return key ^ (32'h1 << $urandom_range(0, 31));
         1: return {8'($urandom), key[23:0]};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input logic kind, input logic [COLOR_W-1:0] color);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pixel_color <= color;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel_beat(kind, color);
      if (kind == KIND_FLUSH) begin
         flush_beats++;
      end else begin
         pixel_beats++;
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (sb.expected_marks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flush_pending_row();
      while (sb.ring_fill != 0) send_beat(KIND_FLUSH, $urandom);
      send_beat(KIND_FLUSH, $urandom);
   endtask

   task automatic program_sizes(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
                                input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [SIZE_W-1:0] val [4];
      idx = '{CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_SRC_WIDTH, CSR_SRC_HEIGHT};
      val = '{fw, fh, sw, sh};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_size(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      size_settings++;
   endtask

   task automatic run_random_phase(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
                                   input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                                   input int pixels, input bit quiet);
      int target_pct;
      int frame_px;
      int n;
      hold_until_drained();
      sender_idle_pct = quiet ? 0 : pick_idle_pct();
      sink_idle_pct = quiet ? 0 : pick_idle_pct();
      program_sizes(fw, fh, sw, sh);
      frame_px = sb.eff_width() * sb.eff_height();
      target_pct = 50;
      for (int i = 0; i < pixels; i++) begin
         if (i % frame_px == 0) begin
            target_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 95);
         end
         if ($urandom_range(0, 99) < 2) begin
            n = $urandom_range(1, sb.ring_fill + 1);
            repeat (n) send_beat(KIND_FLUSH, $urandom);
         end
         if ($urandom_range(0, 299) == 0) hold_until_drained();
         send_beat(KIND_PIXEL, pick_color(target_pct));
      end
      flush_pending_row();
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = pick_idle_pct();
      sink_idle_pct = pick_idle_pct();

      // Run on the sizes left by reset, then end the frame early by shrinking it.
      repeat (20) send_beat(KIND_PIXEL, pick_color(60));
      flush_pending_row();
      hold_until_drained();
      program_sizes(11'd21, 11'd1, SRC_WIDTH_RESET, SRC_HEIGHT_RESET);
      send_beat(KIND_PIXEL, KEY_OPAQUE);
      flush_pending_row();

      hold_until_drained();
      program_sizes(11'd4, 11'd4, 11'd3, 11'd2);
      for (int i = 0; i < 16; i++) send_beat(KIND_PIXEL, DIRECTED_4X4[i]);
      flush_pending_row();

      run_random_phase(11'd0, 11'd0, 11'd0, 11'd0, 40, 1'b0);
      run_random_phase(11'd6, 11'd5, 11'd1024, 11'd1024, 120, 1'b0);
      run_random_phase(11'd9, 11'd7, 11'd4, 11'd3, 126, 1'b0);
      run_random_phase(11'd2047, 11'd1, 11'd700, 11'd1, 1024, 1'b0);
      run_random_phase(11'd3, 11'd3, 11'd2047, 11'd2047, 90, 1'b0);
      run_random_phase(11'd0, 11'd2047, 11'd2047, 11'd2047, 600, 1'b1);
      hold_until_drained();

      $display("Checked %0d result beats (%0d interior, %0d boundary targets) over %0d size settings.",
               sb.results_checked, sb.interior_seen, sb.boundary_seen, size_settings);
      $display("Sent %0d pixel beats and %0d flush beats; %0d mismatches.",
               pixel_beats, flush_beats, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
